FILE: rtl/core/iida_pkg.sv
// Shared types and constants for the indexed insert/delete array.
// Holds the transaction structs, function and status codes, and the cell command.
// No dependencies.
`timescale 1ns / 1ps

package iida_pkg;

   localparam int DEPTH = 64;
   localparam int DATA_W = 32;
   localparam int IDX_W = 8;
   localparam int CNT_W = 7;

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]               func;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [CNT_W-1:0]         count;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

FILE: rtl/core/iida_cell.sv
// One storage cell of the insert/delete array chain.
// Takes its neighbors' entries on insert or delete and drives its entry onto the read bus.
// Depends on iida_pkg.
`timescale 1ns / 1ps

module iida_cell (
   input  logic                        clock,
   input  iida_pkg::cell_cmd_type      cmd,
   input  logic [iida_pkg::IDX_W-1:0]  cell_index,
   input  logic [iida_pkg::DATA_W-1:0] left_data,
   input  logic [iida_pkg::DATA_W-1:0] right_data,
   output logic [iida_pkg::DATA_W-1:0] data_out,
   output logic [iida_pkg::DATA_W-1:0] read_out
);
   import iida_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         if (cell_index == cmd.pos) begin
            data_in = cmd.value;
         end else if (cell_index > cmd.pos) begin
            data_in = left_data;
         end
      end else if (cmd.shift_down) begin
         if (cell_index >= cmd.pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign read_out = (cell_index == cmd.pos) ? data_ff : '0;

endmodule

FILE: rtl/core/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete array: request decode, fill count,
// the row of cells and the registered response. Depends on iida_pkg and iida_cell.
`timescale 1ns / 1ps

// The block keeps an ordered list of up to 64 signed 32-bit entries. Each request
// transaction appends, inserts at an index, deletes at an index or reads at an
// index, and returns exactly one response transaction with the read value, the
// new count and a status. The row of cells moves every entry in the same cycle,
// so a request is accepted every cycle while the output register is empty or its
// response is taken in the same cycle; the response to a request appears in the
// output register in the cycle after acceptance.
module indexed_insert_delete_array (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iida_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output iida_pkg::rsp_type rsp_data
);
   import iida_pkg::*;

   logic [CNT_W-1:0]  fill_count_ff;
   logic [CNT_W-1:0]  fill_count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;
   logic              req_accept;
   logic [IDX_W-1:0]  count_ext;
   logic [IDX_W-1:0]  pos;
   logic [1:0]        status;
   logic              op_ok;
   cell_cmd_type      cmd;
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DATA_W-1:0] cell_read [DEPTH];
   logic [DATA_W-1:0] read_bus;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign count_ext  = IDX_W'(fill_count_ff);
   assign pos = (req_data.func == FUNC_APPEND) ? count_ext : req_data.index;

   always_comb begin
      status = STATUS_OK;
      unique case (req_data.func)
         FUNC_APPEND, FUNC_INSERT: begin
            if (pos > count_ext) begin
               status = STATUS_RANGE;
            end else if (fill_count_ff >= CNT_W'(DEPTH)) begin
               status = STATUS_FULL;
            end
         end
         FUNC_DELETE, FUNC_READ: begin
            if (req_data.index >= count_ext) begin
               status = STATUS_RANGE;
            end
         end
         default: status = STATUS_OK;
      endcase
   end

   assign op_ok = req_accept && (status == STATUS_OK);

   always_comb begin
      cmd.shift_up   = op_ok && ((req_data.func == FUNC_APPEND) ||
                                 (req_data.func == FUNC_INSERT));
      cmd.shift_down = op_ok && (req_data.func == FUNC_DELETE);
      cmd.pos        = pos;
      cmd.value      = req_data.value;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      iida_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i]),
         .read_out   (cell_read[i])
      );
   end

   always_comb begin
      read_bus = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_bus = read_bus | cell_read[i];
      end
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      if (cmd.shift_up) begin
         fill_count_in = fill_count_ff + CNT_W'(1);
      end else if (cmd.shift_down) begin
         fill_count_in = fill_count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.count      = fill_count_in;
         rsp_data_in.status     = status;
         rsp_data_in.read_value = (op_ok && (req_data.func == FUNC_READ)) ?
                                  read_bus : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(DEPTH))
      else $error("fill count exceeds depth");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.func == FUNC_APPEND) && (status == STATUS_OK)) |=>
      (fill_count_ff == $past(fill_count_ff) + CNT_W'(1)))
      else $error("successful append did not grow the count");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.count == fill_count_ff))
      else $error("response count differs from fill count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != STATUS_OK)) |->
      (rsp_data_ff.read_value == '0))
      else $error("failed request returned a nonzero read value");

endmodule
